[sv/cau_pkg.sv]
// Shared operation codes and the action decoder of the complex arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;

  // action codes as they arrive on the input stream
  localparam logic [2:0] ACT_ADD  = 3'd0;
  localparam logic [2:0] ACT_SUB  = 3'd1;
  localparam logic [2:0] ACT_MUL  = 3'd2;
  localparam logic [2:0] ACT_DIV  = 3'd3;
  localparam logic [2:0] ACT_CONJ = 3'd4;

  localparam int unsigned OP_BITS = 3;

  // internal operation class carried from front to back
  typedef enum logic [OP_BITS-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_NONE = 3'd5
  } cau_op_e;

  function automatic cau_op_e decode_action(logic [2:0] act);
    cau_op_e op;
    unique case (act)
      ACT_ADD:  op = OP_ADD;
      ACT_SUB:  op = OP_SUB;
      ACT_MUL:  op = OP_MUL;
      ACT_DIV:  op = OP_DIV;
      ACT_CONJ: op = OP_CONJ;
      default:  op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

[sv/cau_front.sv]
// Front stage: accept input words and classify the action.
`timescale 1ns / 1ps
`default_nettype none
module cau_front #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire [((4*DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // a_re, a_im, b_re, b_im
  input  wire [2:0]                            s_axis_tuser,  // action
  output logic                                 item_valid_o,
  input  wire                                  item_ready_i,
  output logic [cau_pkg::OP_BITS+4*DATA_WIDTH-1:0] item_o
);

  localparam int unsigned IW = cau_pkg::OP_BITS + 4*DATA_WIDTH;

  logic          valid_q, valid_d;
  logic [IW-1:0] item_q;
  logic          take;

  assign s_axis_tready = !valid_q || item_ready_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= {s_axis_tdata[4*DATA_WIDTH-1:0], cau_pkg::decode_action(s_axis_tuser)};
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule
`default_nettype wire

[sv/cau_fifo.sv]
// Short queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module cau_fifo #(
  parameter int unsigned WIDTH = 67,
  parameter int unsigned DEPTH = 4
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire [WIDTH-1:0]  in_data_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             push, pop;

  assign in_ready_o  = cnt_q != (AW+1)'(DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_q] <= in_data_i;
    end
  end

  cnt_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(DEPTH))
    else $error("queue count above depth");
  empty_flag_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty queue with pointers apart");
  full_flag_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (AW+1)'(DEPTH)) |-> (wr_q == rd_q))
    else $error("full queue with pointers apart");

endmodule
`default_nettype wire

[sv/cau_back.sv]
// Back pipeline: products, combine, magnitude, restoring divide, saturate.
`timescale 1ns / 1ps
`default_nettype none
module cau_back #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      in_valid_i,
  output logic                                     in_ready_o,
  input  wire [cau_pkg::OP_BITS+4*DATA_WIDTH-1:0]  in_item_i,
  output logic                                     out_valid_o,
  input  wire                                      out_ready_i,
  output logic [DATA_WIDTH-1:0]                    res_re_o,
  output logic [DATA_WIDTH-1:0]                    res_im_o,
  output logic                                     overflow_o,
  output logic                                     div_by_zero_o
);

  localparam int unsigned DW  = DATA_WIDTH;
  localparam int unsigned M   = 2*DW;
  localparam int unsigned RW  = M + FRAC_BITS;
  localparam int unsigned CW  = M + FRAC_BITS + DW + 1;
  localparam int unsigned QW  = DW + 1;
  localparam int unsigned NS  = DW + 1;
  localparam int unsigned NST = DW + 6;
  localparam int unsigned OB  = cau_pkg::OP_BITS;
  localparam logic [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};
  localparam logic [M-1:0]  NEG_LIM = M'(1) << (DW-1);
  localparam logic [M-1:0]  POS_LIM = NEG_LIM - M'(1);

  logic [NST-1:0] vld_q;
  logic           en;

  assign en         = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // stage A: products and short sums
  cau_pkg::cau_op_e      op_in;
  logic signed [DW-1:0]  ar, ai, br, bi;
  assign op_in = cau_pkg::cau_op_e'(in_item_i[OB-1:0]);
  assign ar    = signed'(in_item_i[OB      +: DW]);
  assign ai    = signed'(in_item_i[OB+DW   +: DW]);
  assign br    = signed'(in_item_i[OB+2*DW +: DW]);
  assign bi    = signed'(in_item_i[OB+3*DW +: DW]);

  cau_pkg::cau_op_e     a_op_q;
  logic signed [M-1:0]  p_rr_q, p_ii_q, p_ri_q, p_ir_q, sq_r_q, sq_i_q;
  logic signed [DW:0]   s_re_q, s_im_q, s_re_d, s_im_d;

  always_comb begin
    unique case (op_in)
      cau_pkg::OP_ADD: begin
        s_re_d = (DW+1)'(ar) + (DW+1)'(br);
        s_im_d = (DW+1)'(ai) + (DW+1)'(bi);
      end
      cau_pkg::OP_SUB: begin
        s_re_d = (DW+1)'(ar) - (DW+1)'(br);
        s_im_d = (DW+1)'(ai) - (DW+1)'(bi);
      end
      cau_pkg::OP_CONJ: begin
        s_re_d = (DW+1)'(ar);
        s_im_d = -(DW+1)'(ai);
      end
      default: begin
        s_re_d = '0;
        s_im_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_op_q <= op_in;
      p_rr_q <= M'(ar) * M'(br);
      p_ii_q <= M'(ai) * M'(bi);
      p_ri_q <= M'(ar) * M'(bi);
      p_ir_q <= M'(ai) * M'(br);
      sq_r_q <= M'(br) * M'(br);
      sq_i_q <= M'(bi) * M'(bi);
      s_re_q <= s_re_d;
      s_im_q <= s_im_d;
    end
  end

  // stage B: combine products into exact signed parts
  cau_pkg::cau_op_e     b_op_q;
  logic signed [M:0]    val_re_q, val_im_q, val_re_d, val_im_d;
  logic [M-1:0]         b_den_q;

  always_comb begin
    unique case (a_op_q)
      cau_pkg::OP_MUL: begin
        val_re_d = (M+1)'(p_rr_q) - (M+1)'(p_ii_q);
        val_im_d = (M+1)'(p_ri_q) + (M+1)'(p_ir_q);
      end
      cau_pkg::OP_DIV: begin
        val_re_d = (M+1)'(p_rr_q) + (M+1)'(p_ii_q);
        val_im_d = (M+1)'(p_ir_q) - (M+1)'(p_ri_q);
      end
      default: begin
        val_re_d = (M+1)'(s_re_q);
        val_im_d = (M+1)'(s_im_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_op_q   <= a_op_q;
      val_re_q <= val_re_d;
      val_im_q <= val_im_d;
      b_den_q  <= unsigned'(sq_r_q) + unsigned'(sq_i_q);
    end
  end

  // stage C: sign and magnitude, product scaling
  cau_pkg::cau_op_e c_op_q;
  logic             c_neg_re_q, c_neg_im_q, c_dz_q;
  logic [M-1:0]     c_mag_re_q, c_mag_im_q, c_den_q;
  logic [M:0]       abs_re, abs_im;
  logic [M-1:0]     mag_re_d, mag_im_d;

  always_comb begin
    abs_re   = val_re_q[M] ? unsigned'(-val_re_q) : unsigned'(val_re_q);
    abs_im   = val_im_q[M] ? unsigned'(-val_im_q) : unsigned'(val_im_q);
    mag_re_d = abs_re[M-1:0];
    mag_im_d = abs_im[M-1:0];
    if (b_op_q == cau_pkg::OP_MUL) begin
      mag_re_d = mag_re_d >> FRAC_BITS;
      mag_im_d = mag_im_d >> FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_op_q     <= b_op_q;
      c_neg_re_q <= val_re_q[M];
      c_neg_im_q <= val_im_q[M];
      c_mag_re_q <= mag_re_d;
      c_mag_im_q <= mag_im_d;
      c_den_q    <= b_den_q;
      c_dz_q     <= b_den_q == '0;
    end
  end

  // stage D and divide steps: one quotient bit per stage, big flags a quotient
  // past the tracked range
  cau_pkg::cau_op_e dv_op     [NS+1];
  logic             dv_neg_re [NS+1];
  logic             dv_neg_im [NS+1];
  logic             dv_dz     [NS+1];
  logic             dv_big_re [NS+1];
  logic             dv_big_im [NS+1];
  logic [M-1:0]     dv_mag_re [NS+1];
  logic [M-1:0]     dv_mag_im [NS+1];
  logic [M-1:0]     dv_den    [NS+1];
  logic [RW-1:0]    dv_rem_re [NS+1];
  logic [RW-1:0]    dv_rem_im [NS+1];
  logic [QW-1:0]    dv_quo_re [NS+1];
  logic [QW-1:0]    dv_quo_im [NS+1];

  logic [CW-1:0] num_re_w, num_im_w, lim_w;
  assign num_re_w = CW'(c_mag_re_q) << FRAC_BITS;
  assign num_im_w = CW'(c_mag_im_q) << FRAC_BITS;
  assign lim_w    = CW'(c_den_q) << (DW+1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_op[0]     <= c_op_q;
      dv_neg_re[0] <= c_neg_re_q;
      dv_neg_im[0] <= c_neg_im_q;
      dv_dz[0]     <= c_dz_q;
      dv_mag_re[0] <= c_mag_re_q;
      dv_mag_im[0] <= c_mag_im_q;
      dv_den[0]    <= c_den_q;
      dv_big_re[0] <= num_re_w >= lim_w;
      dv_big_im[0] <= num_im_w >= lim_w;
      dv_rem_re[0] <= RW'(c_mag_re_q) << FRAC_BITS;
      dv_rem_im[0] <= RW'(c_mag_im_q) << FRAC_BITS;
      dv_quo_re[0] <= '0;
      dv_quo_im[0] <= '0;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_div
    localparam int unsigned SH = NS - k;
    logic [CW-1:0] dsh, rre, rim;
    logic          ge_re, ge_im;
    assign dsh   = CW'(dv_den[k-1]) << SH;
    assign rre   = CW'(dv_rem_re[k-1]);
    assign rim   = CW'(dv_rem_im[k-1]);
    assign ge_re = rre >= dsh;
    assign ge_im = rim >= dsh;

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_op[k]     <= dv_op[k-1];
        dv_neg_re[k] <= dv_neg_re[k-1];
        dv_neg_im[k] <= dv_neg_im[k-1];
        dv_dz[k]     <= dv_dz[k-1];
        dv_mag_re[k] <= dv_mag_re[k-1];
        dv_mag_im[k] <= dv_mag_im[k-1];
        dv_den[k]    <= dv_den[k-1];
        dv_big_re[k] <= dv_big_re[k-1];
        dv_big_im[k] <= dv_big_im[k-1];
        dv_rem_re[k] <= ge_re ? RW'(rre - dsh) : dv_rem_re[k-1];
        dv_rem_im[k] <= ge_im ? RW'(rim - dsh) : dv_rem_im[k-1];
        dv_quo_re[k] <= dv_quo_re[k-1] | (ge_re ? (QW'(1) << SH) : '0);
        dv_quo_im[k] <= dv_quo_im[k-1] | (ge_im ? (QW'(1) << SH) : '0);
      end
    end
  end

  // output stage: saturate and flag
  function automatic logic [DW:0] saturate(logic neg, logic [M-1:0] m, logic big);
    logic [DW:0] r;
    if (neg) begin
      if (big || m > NEG_LIM) begin
        r = {1'b1, MIN_V};
      end else begin
        r = {1'b0, DW'(-m)};
      end
    end else begin
      if (big || m > POS_LIM) begin
        r = {1'b1, MAX_V};
      end else begin
        r = {1'b0, m[DW-1:0]};
      end
    end
    return r;
  endfunction

  cau_pkg::cau_op_e fop;
  logic [M-1:0]     fm_re, fm_im;
  logic             fb_re, fb_im;
  logic [DW:0]      sat_re, sat_im;
  logic [DW-1:0]    res_re_d, res_im_d;
  logic             ovf_d, dz_d;

  always_comb begin
    fop    = dv_op[NS];
    fm_re  = dv_mag_re[NS];
    fm_im  = dv_mag_im[NS];
    fb_re  = 1'b0;
    fb_im  = 1'b0;
    if (fop == cau_pkg::OP_DIV) begin
      fm_re = M'(dv_quo_re[NS]);
      fm_im = M'(dv_quo_im[NS]);
      fb_re = dv_big_re[NS];
      fb_im = dv_big_im[NS];
    end
    sat_re   = saturate(dv_neg_re[NS], fm_re, fb_re);
    sat_im   = saturate(dv_neg_im[NS], fm_im, fb_im);
    res_re_d = sat_re[DW-1:0];
    res_im_d = sat_im[DW-1:0];
    ovf_d    = sat_re[DW] || sat_im[DW];
    dz_d     = 1'b0;
    if (fop == cau_pkg::OP_NONE || (fop == cau_pkg::OP_DIV && dv_dz[NS])) begin
      res_re_d = '0;
      res_im_d = '0;
      ovf_d    = 1'b0;
      dz_d     = fop == cau_pkg::OP_DIV;
    end
  end

  logic [DW-1:0] res_re_q, res_im_q;
  logic          ovf_q, dz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      ovf_q    <= ovf_d;
      dz_q     <= dz_d;
    end
  end

  assign out_valid_o   = vld_q[NST-1];
  assign res_re_o      = res_re_q;
  assign res_im_o      = res_im_q;
  assign overflow_o    = ovf_q;
  assign div_by_zero_o = dz_q;

  dz_zero_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dz_q) |-> (res_re_q == '0 && res_im_q == '0 && !ovf_q))
    else $error("zero divisor result not cleared");
  ovf_limit_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ovf_q) |-> (res_re_q == MAX_V || res_re_q == MIN_V ||
                                res_im_q == MAX_V || res_im_q == MIN_V))
    else $error("overflow flagged without a saturated part");
  stall_hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NST-1] && !out_ready_i) |=> $stable(vld_q))
    else $error("pipeline moved while output stalled");

endmodule
`default_nettype wire

[sv/complex_arith_unit.sv]
// Top level of the complex arithmetic unit: front, queue and back pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Complex arithmetic on signed fixed point words (Q8.8 by default): add,
// subtract, multiply, divide a by b, or conjugate of a, chosen by the action
// in s_axis_tuser. While m_axis_tready holds, the unit takes one word per
// cycle and gives one result word per cycle. A word passes the front
// register, the queue, then the DATA_WIDTH + 6 register stages of the back
// pipeline, whose depth is set by the restoring divider: it resolves one
// quotient bit per pipeline stage for all operations alike so results leave
// in order. Products and quotients truncate toward zero, parts out of range
// saturate and raise overflow, and a zero divisor gives zero with
// div_by_zero raised. Unused action codes give a zero result with both flags
// low. Nothing is kept between words.
module complex_arith_unit #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // input stream
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire [((4*DATA_WIDTH+7)/8)*8-1:0]  s_axis_tdata,  // a_re, a_im, b_re, b_im
  input  wire [2:0]                         s_axis_tuser,  // action
  // result stream
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,  // res_re, res_im
  output logic [1:0]                        m_axis_tuser   // overflow, div_by_zero
);

  localparam int unsigned IW   = cau_pkg::OP_BITS + 4*DATA_WIDTH;
  localparam int unsigned OTDW = ((2*DATA_WIDTH+7)/8)*8;

  logic          fr_valid, fr_ready;
  logic [IW-1:0] fr_item;
  logic          q_valid, q_ready;
  logic [IW-1:0] q_item;
  logic [DATA_WIDTH-1:0] res_re, res_im;
  logic          ovf, dz;

  // accept and classify
  cau_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid_o  (fr_valid),
    .item_ready_i  (fr_ready),
    .item_o        (fr_item)
  );

  // decouple front from back so each side can stall on its own
  cau_fifo #(.WIDTH(IW), .DEPTH(4)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_data_i   (fr_item),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_item)
  );

  // compute, divide and saturate
  cau_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (q_valid),
    .in_ready_o    (q_ready),
    .in_item_i     (q_item),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .res_re_o      (res_re),
    .res_im_o      (res_im),
    .overflow_o    (ovf),
    .div_by_zero_o (dz)
  );

  // pack the result word, zero fill to whole bytes
  assign m_axis_tdata = OTDW'({res_im, res_re});
  assign m_axis_tuser = {dz, ovf};

endmodule
`default_nettype wire
